>>> src/xsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR scan block store package
// Sizes, register and command codes, and the types shared by the block's
// modules.
// ----------------------------------------------------------------------------
package xsb_pkg;

    localparam int NUM_BLOCKS      = 1024;
    localparam int WORDS_PER_BLOCK = 16;

    localparam int DATA_W   = 64;
    localparam int BLK_W    = 10;
    localparam int WRD_W    = $clog2(WORDS_PER_BLOCK);
    localparam int ADDR_W   = $clog2(NUM_BLOCKS) + WRD_W;
    localparam int MEM_DEPTH = NUM_BLOCKS * WORDS_PER_BLOCK;
    localparam int NB_W     = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W    = $clog2(WORDS_PER_BLOCK + 1);

    localparam int CMD_W          = 2;
    localparam int BLOCK_COUNT_W  = 11;
    localparam int BLOCK_WORDS_W  = 5;
    localparam int ADV_W          = 10;
    localparam int ADV_BIT_W      = $clog2(DATA_W);
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WORDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADVICE_BIT  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_LOAD_Z = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_SWEEP,
        ST_OUT
    } state_t;

    // Effective configuration, already clamped to the legal ranges.
    typedef struct packed {
        logic [NB_W-1:0]  blocks;
        logic [CNT_W-1:0] words;
        logic [ADV_W-1:0] advice;
    } cfg_t;

    typedef struct packed {
        logic [WRD_W-1:0]  word_index;
        logic [DATA_W-1:0] word;
        logic              last;
    } out_item_t;

endpackage
`default_nettype wire

>>> src/xsb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module xsb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/xsb_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR scan engine
// Sequencer around the block store: clearing pass, read-modify-write of a
// word, Z correction and select sweeps, and the read-out of the accumulator.
// ----------------------------------------------------------------------------
module xsb_engine import xsb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CMD_W-1:0]  s_cmd,
    input  wire logic [BLK_W-1:0]  s_block_index,
    input  wire logic [WRD_W-1:0]  s_word_index,
    input  wire logic [DATA_W-1:0] s_data_word,
    input  wire logic              s_select_bit,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item
);

    state_t state_reg, state_next;

    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [WRD_W-1:0]  wrd_reg, wrd_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              sweep_z_reg, sweep_z_next;
    logic              last_blk_reg, last_blk_next;
    logic              advice_seen_reg, advice_seen_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [WRD_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [WRD_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [DATA_W-1:0] z_reg   [WORDS_PER_BLOCK];
    logic [DATA_W-1:0] acc_reg [WORDS_PER_BLOCK];

    logic              z_we;
    logic              acc_xor;
    logic              acc_clr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic accept;
    logic wrd_ok;
    logic blk_ok;
    logic blk_last;
    logic wb_last;
    logic adv_hit;
    logic seen_new;
    logic issue;
    logic out_last;

    xsb_ram #(
        .DEPTH(MEM_DEPTH),
        .WIDTH(DATA_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign accept   = s_valid && s_ready;
    assign wrd_ok   = CNT_W'(s_word_index) < cfg.words;
    assign blk_ok   = NB_W'(s_block_index) < cfg.blocks;
    assign blk_last = NB_W'(s_block_index) == (cfg.blocks - NB_W'(1));
    assign wb_last  = CNT_W'(wrd_reg) == (cfg.words - CNT_W'(1));
    assign adv_hit  = wrd_reg == cfg.advice[ADV_W-1:ADV_BIT_W];
    assign seen_new = adv_hit ? data_reg[cfg.advice[ADV_BIT_W-1:0]] : advice_seen_reg;
    assign issue    = rd_cnt_reg < cfg.words;
    assign out_last = CNT_W'(out_cnt_reg) == (cfg.words - CNT_W'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        CMD_WRITE: begin
                            if (wrd_ok && blk_ok) begin
                                state_next = ST_WR_RD;
                            end
                        end
                        CMD_SELECT: begin
                            if (blk_ok && s_select_bit) begin
                                state_next = ST_SWEEP;
                            end else if (blk_ok && blk_last) begin
                                state_next = ST_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WR_RD: state_next = ST_WR_WB;
            ST_WR_WB: begin
                state_next = (wb_last && seen_new) ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP: begin
                if (!issue) begin
                    state_next = (!sweep_z_reg && last_blk_reg) ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_ready && out_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        s_ready          = 1'b0;
        out_valid        = 1'b0;
        z_we             = 1'b0;
        acc_xor          = 1'b0;
        acc_clr          = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = {blk_reg, wrd_reg};
        ram_wdata        = ram_rdata ^ data_reg;
        ram_re           = 1'b0;
        ram_raddr        = {blk_reg, wrd_reg};
        blk_next         = blk_reg;
        wrd_next         = wrd_reg;
        data_next        = data_reg;
        sweep_z_next     = sweep_z_reg;
        last_blk_next    = last_blk_reg;
        advice_seen_next = advice_seen_reg;
        clr_cnt_next     = clr_cnt_reg;
        rd_cnt_next      = rd_cnt_reg;
        pend_valid_next  = 1'b0;
        pend_idx_next    = pend_idx_reg;
        out_cnt_next     = out_cnt_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    blk_next      = s_block_index;
                    wrd_next      = s_word_index;
                    data_next     = s_data_word;
                    last_blk_next = blk_last;
                    sweep_z_next  = 1'b0;
                    rd_cnt_next   = '0;
                    z_we          = (s_cmd == CMD_LOAD_Z) && wrd_ok;
                end
            end
            ST_WR_RD: begin
                ram_re = 1'b1;
            end
            ST_WR_WB: begin
                ram_we = 1'b1;
                // The noted bit is consumed and dropped on every last-word write.
                advice_seen_next = wb_last ? 1'b0 : seen_new;
                sweep_z_next     = 1'b1;
                rd_cnt_next      = '0;
            end
            ST_SWEEP: begin
                // Reads run one word ahead of the write-back, so the two ports
                // never touch the same entry in one cycle.
                if (issue) begin
                    ram_re      = 1'b1;
                    ram_raddr   = {blk_reg, rd_cnt_reg[WRD_W-1:0]};
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                pend_valid_next = issue;
                pend_idx_next   = rd_cnt_reg[WRD_W-1:0];
                if (pend_valid_reg) begin
                    if (sweep_z_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = {blk_reg, pend_idx_reg};
                        ram_wdata = ram_rdata ^ z_reg[pend_idx_reg];
                    end else begin
                        acc_xor = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (out_last) begin
                        out_cnt_next = '0;
                        acc_clr      = 1'b1;
                    end else begin
                        out_cnt_next = out_cnt_reg + WRD_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign out_item = '{
        word_index: out_cnt_reg,
        word:       acc_reg[out_cnt_reg],
        last:       out_last
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            advice_seen_reg <= 1'b0;
            rd_cnt_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            out_cnt_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            advice_seen_reg <= advice_seen_next;
            rd_cnt_reg      <= rd_cnt_next;
            pend_valid_reg  <= pend_valid_next;
            out_cnt_reg     <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg      <= blk_next;
        wrd_reg      <= wrd_next;
        data_reg     <= data_next;
        sweep_z_reg  <= sweep_z_next;
        last_blk_reg <= last_blk_next;
        pend_idx_reg <= pend_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                z_reg[i]   <= '0;
                acc_reg[i] <= '0;
            end
        end else begin
            if (z_we) begin
                z_reg[s_word_index] <= s_data_word;
            end
            if (acc_clr) begin
                for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                    acc_reg[i] <= '0;
                end
            end else if (acc_xor) begin
                acc_reg[pend_idx_reg] <= acc_reg[pend_idx_reg] ^ ram_rdata;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/xsb_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output register
// Holds one result word for the downstream side and refills in the cycle
// it is taken.
// ----------------------------------------------------------------------------
module xsb_out_stage import xsb_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire out_item_t in_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic [WRD_W-1:0]  m_out_word_index,
    output logic [DATA_W-1:0] m_out_word,
    output logic           m_last
);

    logic      valid_reg;
    out_item_t item_reg;

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign m_valid          = valid_reg;
    assign m_out_word_index = item_reg.word_index;
    assign m_out_word       = item_reg.word;
    assign m_last           = item_reg.last;

endmodule
`default_nettype wire

>>> src/xor_scan_block_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR scan block store
// Block store with XOR writes, advice-bit Z correction and an XOR read over
// selected blocks.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the store, one word per
// cycle, and accepts no transaction until it is done; configuration writes
// are taken throughout. A load Z transaction, and any transaction that is out
// of range or carries an unknown command, is handled without leaving idle. A
// write transaction reads the word and then writes it back through the
// single-read, single-write store; when it completes a block with the advice
// bit set, the Z correction sweep follows. A select transaction with its bit
// set sweeps the block, one store read per cycle. After the final block the
// result is streamed at one word per cycle while the receiver is ready, and
// the next transaction is accepted while the last word still waits in the
// output register.
module xor_scan_block_store import xsb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CMD_W-1:0]      s_cmd,
    input  wire logic [BLK_W-1:0]      s_block_index,
    input  wire logic [WRD_W-1:0]      s_word_index,
    input  wire logic [DATA_W-1:0]     s_data_word,
    input  wire logic                  s_select_bit,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WRD_W-1:0]           m_out_word_index,
    output logic [DATA_W-1:0]          m_out_word,
    output logic                       m_last
);

    logic [BLOCK_COUNT_W-1:0] block_count_reg;
    logic [BLOCK_WORDS_W-1:0] block_words_reg;
    logic [ADV_W-1:0]         advice_bit_reg;

    cfg_t      cfg;
    logic      eng_valid;
    logic      eng_ready;
    out_item_t eng_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= BLOCK_COUNT_W'(NUM_BLOCKS);
            block_words_reg <= BLOCK_WORDS_W'(WORDS_PER_BLOCK);
            advice_bit_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[BLOCK_COUNT_W-1:0];
                REG_BLOCK_WORDS: block_words_reg <= cfg_wdata[BLOCK_WORDS_W-1:0];
                REG_ADVICE_BIT:  advice_bit_reg  <= cfg_wdata[ADV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Zero counts act as one; counts above the store size are clamped.
    always_comb begin
        if (block_count_reg == '0) begin
            cfg.blocks = NB_W'(1);
        end else if (32'(block_count_reg) > NUM_BLOCKS) begin
            cfg.blocks = NB_W'(NUM_BLOCKS);
        end else begin
            cfg.blocks = NB_W'(block_count_reg);
        end
        if (block_words_reg == '0) begin
            cfg.words = CNT_W'(1);
        end else if (32'(block_words_reg) > WORDS_PER_BLOCK) begin
            cfg.words = CNT_W'(WORDS_PER_BLOCK);
        end else begin
            cfg.words = CNT_W'(block_words_reg);
        end
        cfg.advice = advice_bit_reg;
    end

    xsb_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_block_index(s_block_index),
        .s_word_index (s_word_index),
        .s_data_word  (s_data_word),
        .s_select_bit (s_select_bit),
        .out_valid    (eng_valid),
        .out_ready    (eng_ready),
        .out_item     (eng_item)
    );

    xsb_out_stage u_out_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (eng_valid),
        .in_ready        (eng_ready),
        .in_item         (eng_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_word_index(m_out_word_index),
        .m_out_word      (m_out_word),
        .m_last          (m_last)
    );

endmodule
`default_nettype wire

>>> src/xsb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XOR scan block store checker
// Port-level checks on reset, result streaming and the result handshake.
// ----------------------------------------------------------------------------
module xsb_port_checker import xsb_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [WRD_W-1:0]  m_out_word_index,
    input wire logic [DATA_W-1:0] m_out_word,
    input wire logic              m_last
);

    // The store is being cleared after reset, so nothing is taken.
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input accepted straight after reset");

    // A result is streamed without gaps and with rising word positions.
    a_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && (m_out_word_index == WRD_W'($past(m_out_word_index) + 1'b1)))
        else $error("result stream broken");

    // A result that follows the final word starts again at word position zero.
    a_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || (m_out_word_index == '0))
        else $error("result after the final word does not start at word zero");

    // While a result is being streamed no new transaction is taken.
    a_busy_streaming: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input accepted during result streaming");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=>
            m_valid && $stable(m_out_word) && $stable(m_out_word_index) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind xor_scan_block_store xsb_port_checker u_xsb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_word_index(m_out_word_index),
    .m_out_word      (m_out_word),
    .m_last          (m_last)
);
`default_nettype wire

>>> verif/xsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR scan block store checker
// Watches the configuration port and both channels, keeps its own copy of the
// store, the Z block and the read accumulator, and compares each result
// transaction field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module xsb_checker import xsb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [BLK_W-1:0]      s_block_index,
    input  logic [WRD_W-1:0]      s_word_index,
    input  logic [DATA_W-1:0]     s_data_word,
    input  logic                  s_select_bit,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [WRD_W-1:0]      m_out_word_index,
    input  logic [DATA_W-1:0]     m_out_word,
    input  logic                  m_last,
    output int unsigned           fail_count,
    output int unsigned           expected_left
);

    localparam int unsigned MAX_REPORTS = 10;

    logic [DATA_W-1:0]        store_mem [MEM_DEPTH];
    logic [DATA_W-1:0]        z_block   [WORDS_PER_BLOCK];
    logic [DATA_W-1:0]        read_acc  [WORDS_PER_BLOCK];
    logic                     advice_latched;
    logic [BLOCK_COUNT_W-1:0] block_count_r;
    logic [BLOCK_WORDS_W-1:0] block_words_r;
    logic [ADV_W-1:0]         advice_r;
    out_item_t                expected_words [$];
    int unsigned              failures;

    function automatic int unsigned blocks_in_use();
        if (block_count_r == 0) return 1;
        if (block_count_r > NUM_BLOCKS) return NUM_BLOCKS;
        return block_count_r;
    endfunction

    function automatic int unsigned words_in_use();
        if (block_words_r == 0) return 1;
        if (block_words_r > WORDS_PER_BLOCK) return WORDS_PER_BLOCK;
        return block_words_r;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Applies one accepted transaction to the local copy of the store and
    // queues the read words that it releases.
    task automatic update_store(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk,
                                input logic [WRD_W-1:0] wrd, input logic [DATA_W-1:0] data,
                                input logic sel);
        int unsigned nb;
        int unsigned nw;
        int unsigned base;
        int unsigned j;
        out_item_t   res;
        nb   = blocks_in_use();
        nw   = words_in_use();
        base = blk * WORDS_PER_BLOCK;
        case (cmd)
            CMD_LOAD_Z: begin
                if (wrd < nw) z_block[wrd] = data;
            end
            CMD_WRITE: begin
                if (wrd < nw && blk < nb) begin
                    store_mem[base + wrd] = store_mem[base + wrd] ^ data;
                    // The latch is shared by all blocks; only the word position counts.
                    if (wrd == advice_r[ADV_W-1:ADV_BIT_W])
                        advice_latched = data[advice_r[ADV_BIT_W-1:0]];
                    if (wrd == nw - 1) begin
                        if (advice_latched) begin
                            for (j = 0; j < nw; j++)
                                store_mem[base + j] = store_mem[base + j] ^ z_block[j];
                        end
                        advice_latched = 1'b0;
                    end
                end
            end
            CMD_SELECT: begin
                if (blk < nb) begin
                    if (sel) begin
                        for (j = 0; j < nw; j++)
                            read_acc[j] = read_acc[j] ^ store_mem[base + j];
                    end
                    if (blk == nb - 1) begin
                        for (j = 0; j < nw; j++) begin
                            res.word_index = WRD_W'(j);
                            res.word       = read_acc[j];
                            res.last       = (j == nw - 1);
                            expected_words.push_back(res);
                        end
                        for (j = 0; j < WORDS_PER_BLOCK; j++) read_acc[j] = '0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        out_item_t   want;
        int unsigned k;
        if (!aresetn) begin
            for (k = 0; k < MEM_DEPTH; k++) store_mem[k] = '0;
            for (k = 0; k < WORDS_PER_BLOCK; k++) begin
                z_block[k]  = '0;
                read_acc[k] = '0;
            end
            advice_latched = 1'b0;
            block_count_r  = BLOCK_COUNT_W'(NUM_BLOCKS);
            block_words_r  = BLOCK_WORDS_W'(WORDS_PER_BLOCK);
            advice_r       = '0;
            expected_words.delete();
            failures       = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BLOCK_COUNT: block_count_r = cfg_wdata[BLOCK_COUNT_W-1:0];
                    REG_BLOCK_WORDS: block_words_r = cfg_wdata[BLOCK_WORDS_W-1:0];
                    REG_ADVICE_BIT:  advice_r      = cfg_wdata[ADV_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    note_failure($sformatf("unexpected result: index %0d word %h last %b",
                                           m_out_word_index, m_out_word, m_last));
                end else begin
                    want = expected_words.pop_front();
                    if (want.word_index !== m_out_word_index || want.word !== m_out_word ||
                        want.last !== m_last) begin
                        note_failure($sformatf(
                            "result mismatch: index exp %0d got %0d, word exp %h got %h, last exp %b got %b",
                            want.word_index, m_out_word_index, want.word, m_out_word,
                            want.last, m_last));
                    end
                end
            end
            if (s_valid && s_ready)
                update_store(s_cmd, s_block_index, s_word_index, s_data_word, s_select_bit);
        end
        fail_count    <= failures;
        expected_left <= expected_words.size();
    end

endmodule

>>> verif/tb_xor_scan_block_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR scan block store testbench
// Drives directed and random transactions through the block across several
// register settings and idling patterns, with a separate checker predicting
// and comparing every read result.
// ----------------------------------------------------------------------------
module tb_xor_scan_block_store;
    import xsb_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    // Idle time after draining, so that a write that completes a block can finish its Z correction.
    localparam int unsigned SETTLE_CYCLES   = 48;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned NUM_PHASES      = 8;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd         = '0;
    logic [BLK_W-1:0]      s_block_index = '0;
    logic [WRD_W-1:0]      s_word_index  = '0;
    logic [DATA_W-1:0]     s_data_word   = '0;
    logic                  s_select_bit  = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [WRD_W-1:0]      m_out_word_index;
    logic [DATA_W-1:0]     m_out_word;
    logic                  m_last;

    int unsigned fail_count;
    int unsigned expected_left;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cur_blocks     = NUM_BLOCKS;
    int unsigned cur_words      = WORDS_PER_BLOCK;
    int unsigned cur_advice     = 0;

    int unsigned phase_blocks [NUM_PHASES] = '{6, 0, 1024, 2047, 3, 8, 5, 2};
    int unsigned phase_words  [NUM_PHASES] = '{4, 1, 16, 31, 0, 16, 7, 2};
    int unsigned phase_advice [NUM_PHASES] = '{100, 5, 1023, 0, 63, 700, 600, 64};
    int unsigned idle_pcts    [4]          = '{0, 54, 0, 23};
    int unsigned stall_pcts   [4]          = '{0, 0, 54, 23};

    xor_scan_block_store i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_block_index    (s_block_index),
        .s_word_index     (s_word_index),
        .s_data_word      (s_data_word),
        .s_select_bit     (s_select_bit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_word_index (m_out_word_index),
        .m_out_word       (m_out_word),
        .m_last           (m_last)
    );

    xsb_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_block_index    (s_block_index),
        .s_word_index     (s_word_index),
        .s_data_word      (s_data_word),
        .s_select_bit     (s_select_bit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_word_index (m_out_word_index),
        .m_out_word       (m_out_word),
        .m_last           (m_last),
        .fail_count       (fail_count),
        .expected_left    (expected_left)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int unsigned clamp_range(input int unsigned value, input int unsigned hi);
        if (value == 0) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    // Presents one transaction, waits for it to be taken, then idles at random.
    task automatic send_txn(input logic [CMD_W-1:0] cmd, input int unsigned blk,
                            input int unsigned wrd, input logic [DATA_W-1:0] data,
                            input logic sel);
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_block_index <= BLK_W'(blk);
        s_word_index  <= WRD_W'(wrd);
        s_data_word   <= data;
        s_select_bit  <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Holds the sender back until every read word has arrived and the block
    // has had time to finish any trailing Z correction.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_left != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input int unsigned blocks, input int unsigned words,
                                input int unsigned advice);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BLOCK_COUNT;
        cfg_wdata <= CFG_DATA_W'(blocks);
        @(posedge aclk);
        cfg_index <= REG_BLOCK_WORDS;
        cfg_wdata <= CFG_DATA_W'(words);
        @(posedge aclk);
        cfg_index <= REG_ADVICE_BIT;
        cfg_wdata <= CFG_DATA_W'(advice);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cur_blocks = clamp_range(blocks, NUM_BLOCKS);
        cur_words  = clamp_range(words, WORDS_PER_BLOCK);
        cur_advice = advice;
    endtask

    // One random step: mostly well-formed activity, with some noise and some
    // block writes broken off part way.
    task automatic random_activity(inout int unsigned done);
        int unsigned      pick;
        int unsigned      blk;
        int unsigned      stop;
        int unsigned      w;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_txn(CMD_W'($urandom_range(0, 3)), $urandom_range(0, NUM_BLOCKS - 1),
                     $urandom_range(0, WORDS_PER_BLOCK - 1), random_word(),
                     1'($urandom_range(0, 1)));
        end else if (pick < 25) begin
            send_txn(CMD_LOAD_Z, $urandom_range(0, NUM_BLOCKS - 1),
                     $urandom_range(0, cur_words - 1), random_word(),
                     1'($urandom_range(0, 1)));
            done++;
        end else if (pick < 60) begin
            blk  = $urandom_range(0, cur_blocks - 1);
            stop = cur_words;
            if (cur_words > 1 && $urandom_range(0, 6) == 0)
                stop = $urandom_range(1, cur_words - 1);
            for (w = 0; w < stop; w++) begin
                data = random_word();
                if (w == cur_advice / DATA_W)
                    data[cur_advice % DATA_W] = 1'($urandom_range(0, 1));
                send_txn(CMD_WRITE, blk, w, data, 1'($urandom_range(0, 1)));
                done++;
            end
        end else begin
            if ($urandom_range(0, 3) == 0) blk = cur_blocks - 1;
            else blk = $urandom_range(0, cur_blocks - 1);
            send_txn(CMD_SELECT, blk, $urandom_range(0, WORDS_PER_BLOCK - 1), random_word(),
                     $urandom_range(0, 4) != 0);
            done++;
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned done;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: 1024 blocks of 16 words, advice on bit 0 of word 0.
        send_txn(CMD_LOAD_Z, 0, 0, '1, 1'b0);
        send_txn(CMD_LOAD_Z, 0, 15, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_txn(CMD_LOAD_Z, 0, 7, random_word(), 1'b0);
        send_txn(CMD_WRITE, 1023, 0, '1, 1'b0);
        send_txn(CMD_WRITE, 1023, 15, '0, 1'b0);
        // The advice noted on one block drives the correction of another.
        send_txn(CMD_WRITE, 5, 0, 64'h1, 1'b0);
        send_txn(CMD_WRITE, 7, 15, 64'hFFFF_0000_FFFF_0000, 1'b0);
        send_txn(CMD_WRITE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        send_txn(CMD_WRITE, 0, 15, '1, 1'b1);
        send_txn(CMD_UNKNOWN, 1023, 15, '1, 1'b1);
        send_txn(CMD_SELECT, 0, 0, '0, 1'b1);
        send_txn(CMD_SELECT, 7, 0, '0, 1'b1);
        send_txn(CMD_SELECT, 5, 0, '0, 1'b0);
        send_txn(CMD_SELECT, 1023, 0, '0, 1'b1);
        send_txn(CMD_SELECT, 1023, 0, '0, 1'b0);
        drain_results();

        // Small store whose advice word lies beyond the block, plus out-of-range items.
        program_regs(4, 3, 200);
        send_txn(CMD_LOAD_Z, 0, 2, random_word(), 1'b0);
        send_txn(CMD_LOAD_Z, 0, 5, random_word(), 1'b0);
        send_txn(CMD_WRITE, 4, 0, '1, 1'b0);
        send_txn(CMD_WRITE, 2, 3, '1, 1'b0);
        send_txn(CMD_WRITE, 2, 0, '1, 1'b0);
        send_txn(CMD_WRITE, 2, 1, '1, 1'b0);
        send_txn(CMD_WRITE, 2, 2, '1, 1'b0);
        send_txn(CMD_SELECT, 5, 0, '0, 1'b1);
        send_txn(CMD_SELECT, 2, 0, '0, 1'b1);
        send_txn(CMD_SELECT, 3, 0, '0, 1'b1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            program_regs(phase_blocks[phase], phase_words[phase], phase_advice[phase]);
            send_idle_pct  = idle_pcts[phase % 4];
            recv_stall_pct = stall_pcts[phase % 4];
            done = 0;
            while (done < ITEMS_PER_PHASE) random_activity(done);
        end
        drain_results();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
